// ===== hdl/elg_pkg.sv =====
// Shared types for the ElGamal cipher unit.
// Used by the multiplier cell and the top level; depends on nothing.
`default_nettype none
package elg_pkg;

  // Destination register of a product leaving the multiplier chain
  typedef enum logic [1:0] {
    TAG_ACC0 = 2'd0,
    TAG_SQ0  = 2'd1,
    TAG_ACC1 = 2'd2,
    TAG_SQ1  = 2'd3
  } tag_e;

  typedef struct packed {
    logic valid;
    tag_e tag;
  } cell_ctl_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MODULUS     = 2'd0,
    REG_GENERATOR   = 2'd1,
    REG_PRIVATE_KEY = 2'd2,
    REG_PUBLIC_KEY  = 2'd3
  } reg_idx_e;

  localparam int unsigned FIELD_BITS = 32;

endpackage
`default_nettype wire

// ===== hdl/elg_mul_cell.sv =====
// One step of the interleaved modular multiplier: acc = 2*acc + bit*a mod p.
// Consumes the top bit of b and passes the shifted b on; uses elg_pkg.
`default_nettype none
module elg_mul_cell import elg_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [WORD_BITS-1:0] mod_i,
  input  cell_ctl_t                 ctl_i,
  input  wire logic [WORD_BITS-1:0] acc_i,
  input  wire logic [WORD_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] b_i,
  output cell_ctl_t                 ctl_o,
  output logic      [WORD_BITS-1:0] acc_o,
  output logic      [WORD_BITS-1:0] a_o,
  output logic      [WORD_BITS-1:0] b_o
);

  logic [WORD_BITS:0] dbl, red1, sum, red2, mod_ext;
  cell_ctl_t ctl_q;
  logic [WORD_BITS-1:0] acc_q, a_q, b_q;

  // acc and a stay below p, so each partial sum stays below 2p
  always_comb begin
    mod_ext = {1'b0, mod_i};
    dbl     = {acc_i, 1'b0};
    red1    = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = red1 + (b_i[WORD_BITS-1] ? {1'b0, a_i} : '0);
    red2    = (sum >= mod_ext) ? sum - mod_ext : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= red2[WORD_BITS-1:0];
    a_q   <= a_i;
    b_q   <= {b_i[WORD_BITS-2:0], 1'b0};
  end

  assign ctl_o = ctl_q;
  assign acc_o = acc_q;
  assign a_o   = a_q;
  assign b_o   = b_q;

endmodule
`default_nettype wire

// ===== hdl/elgamal_encrypt_decrypt.sv =====
// ElGamal encrypt/decrypt unit over a prime modulus of up to WORD_BITS bits.
// Sequence: reduce the bases, then one square-and-multiply pass per exponent bit up to
// the top set bit, then the final product; W = WORD_BITS.
// Throughput: one item at a time, set by the W-cell multiplier chain round trip.
// Reset: asynchronous, active low; registers return to p = 2, g = x = y = 0.
`default_nettype none
module elgamal_encrypt_decrypt import elg_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic [FIELD_BITS-1:0] value_a_i,
  input  wire logic [FIELD_BITS-1:0] value_b_i,
  input  wire logic [FIELD_BITS-1:0] nonce_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [FIELD_BITS-1:0] result_first_o,
  output logic      [FIELD_BITS-1:0] result_second_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [FIELD_BITS-1:0] cfg_data_i
);

  localparam int unsigned W = WORD_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_e;
  typedef enum logic [1:0] {PH_REDUCE, PH_LOOP, PH_FINAL} phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [W-1:0] mod_q, gen_q, priv_q, pub_q;
  logic [W-1:0] acc0_q, sq0_q, acc1_q, sq1_q;
  logic [W-1:0] base0_q, va_q, vb_q, ex_q, ex_d;
  logic         op_q, deg_q;
  logic [1:0]   issue_cnt_q;
  logic [2:0]   ret_cnt_q, n_q;
  logic [FIELD_BITS-1:0] first_q, second_q;
  logic         out_valid_q;

  logic [W-1:0] one_w, pm1, dec_ex, op_a, op_b;
  tag_e         op_tag;

  cell_ctl_t    ctl_c [W+1];
  logic [W-1:0] acc_c [W+1];
  logic [W-1:0] a_c   [W+1];
  logic [W-1:0] b_c   [W+1];

  assign one_w  = W'(1);
  assign pm1    = mod_q - one_w;
  assign dec_ex = (priv_q < pm1) ? pm1 - priv_q : '0;
  assign ex_d   = ex_q >> 1;

  // Operand select for the product launched this cycle
  always_comb begin
    op_a   = one_w;
    op_b   = base0_q;
    op_tag = TAG_SQ0;
    case (phase_q)
      PH_REDUCE: begin
        op_a   = one_w;
        op_b   = (issue_cnt_q == 2'd0) ? base0_q : pub_q;
        op_tag = (issue_cnt_q == 2'd0) ? TAG_SQ0 : TAG_SQ1;
      end
      PH_LOOP: begin
        case (issue_cnt_q)
          2'd0: begin
            op_a = ex_q[0] ? sq0_q : one_w; op_b = acc0_q; op_tag = TAG_ACC0;
          end
          2'd1: begin
            op_a = sq0_q; op_b = sq0_q; op_tag = TAG_SQ0;
          end
          2'd2: begin
            op_a = ex_q[0] ? sq1_q : one_w; op_b = acc1_q; op_tag = TAG_ACC1;
          end
          default: begin
            op_a = sq1_q; op_b = sq1_q; op_tag = TAG_SQ1;
          end
        endcase
      end
      PH_FINAL: begin
        op_a   = op_q ? acc0_q : acc1_q;
        op_b   = op_q ? vb_q : va_q;
        op_tag = TAG_SQ0;
      end
      default: ;
    endcase
  end

  assign ctl_c[0].valid = (state_q == ST_ISSUE);
  assign ctl_c[0].tag   = op_tag;
  assign acc_c[0]       = '0;
  assign a_c[0]         = op_a;
  assign b_c[0]         = op_b;

  for (genvar i = 0; i < W; i++) begin : g_cell
    elg_mul_cell #(.WORD_BITS(W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .mod_i  (mod_q),
      .ctl_i  (ctl_c[i]),
      .acc_i  (acc_c[i]),
      .a_i    (a_c[i]),
      .b_i    (b_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .acc_o  (acc_c[i+1]),
      .a_o    (a_c[i+1]),
      .b_o    (b_c[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_REDUCE;
      mod_q       <= W'(2);
      gen_q       <= '0;
      priv_q      <= '0;
      pub_q       <= '0;
      issue_cnt_q <= '0;
      ret_cnt_q   <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MODULUS:     mod_q  <= cfg_data_i[W-1:0];
          REG_GENERATOR:   gen_q  <= cfg_data_i[W-1:0];
          REG_PRIVATE_KEY: priv_q <= cfg_data_i[W-1:0];
          REG_PUBLIC_KEY:  pub_q  <= cfg_data_i[W-1:0];
          default: ;
        endcase
      end
      // retire a product into its destination register
      if (ctl_c[W].valid) begin
        ret_cnt_q <= ret_cnt_q + 3'd1;
        case (ctl_c[W].tag)
          TAG_ACC0: acc0_q <= acc_c[W];
          TAG_SQ0:  sq0_q  <= acc_c[W];
          TAG_ACC1: acc1_q <= acc_c[W];
          default:  sq1_q  <= acc_c[W];
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q        <= op_i;
            va_q        <= value_a_i[W-1:0];
            vb_q        <= value_b_i[W-1:0];
            base0_q     <= op_i ? value_a_i[W-1:0] : gen_q;
            ex_q        <= op_i ? dec_ex : nonce_i[W-1:0];
            deg_q       <= (mod_q < W'(2));
            acc0_q      <= one_w;
            acc1_q      <= one_w;
            phase_q     <= PH_REDUCE;
            n_q         <= 3'd2;
            issue_cnt_q <= '0;
            ret_cnt_q   <= '0;
            state_q     <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          issue_cnt_q <= issue_cnt_q + 2'd1;
          if (3'(issue_cnt_q) == n_q - 3'd1) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (ret_cnt_q == n_q) begin
            issue_cnt_q <= '0;
            ret_cnt_q   <= '0;
            state_q     <= ST_ISSUE;
            if (phase_q == PH_FINAL) begin
              first_q     <= deg_q ? '0 : FIELD_BITS'(op_q ? sq0_q : acc0_q);
              second_q    <= (deg_q || op_q) ? '0 : FIELD_BITS'(sq0_q);
              out_valid_q <= 1'b1;
              state_q     <= ST_DONE;
            end else begin
              // advance to the next exponent bit, or finish when none remain
              if (phase_q == PH_LOOP) begin
                ex_q <= ex_d;
              end
              if ((phase_q == PH_LOOP ? ex_d : ex_q) == '0) begin
                phase_q <= PH_FINAL;
                n_q     <= 3'd1;
              end else begin
                phase_q <= PH_LOOP;
                n_q     <= 3'd4;
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign result_first_o  = first_q;
  assign result_second_o = second_q;
  assign cfg_ready_o     = 1'b1;

  a_busy_while_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_return_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_c[W].valid |-> (state_q == ST_WAIT))
    else $error("product returned outside the wait state");

  a_ret_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> (ret_cnt_q <= n_q))
    else $error("more products returned than issued");

endmodule
`default_nettype wire
